FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define PRHF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("prhf assertion failed");

// Clocked implication, disabled while reset is held.
`define PRHF_ASSERT_IMPL(label, pre, post) \
  `PRHF_ASSERT(label, (pre) |-> (post))

`endif

FILE: hw/rtl/prhf_pkg.sv
// Package: types and constants of the record header finder.
`default_nettype none

package prhf_pkg;

  localparam int unsigned PositionBitsDef = 32;

  localparam int unsigned OffsetW   = 32;
  localparam int unsigned LengthW   = 16;
  localparam int unsigned FieldW    = 16;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 56;

  localparam int unsigned BoxUuidStart = 8;
  localparam int unsigned SysUuidStart = 28;
  localparam int unsigned UuidLen      = 16;
  localparam int unsigned CountLowPos  = 52;
  localparam int unsigned RecordsStart = 54;

  localparam logic [FieldW-1:0] HeaderRecordType = 16'h0001;

  localparam logic [7:0] BoxUuid [UuidLen] = '{
    8'hD0, 8'h8A, 8'h4F, 8'h18, 8'h10, 8'hF3, 8'h4A, 8'h82,
    8'hB6, 8'hC8, 8'h32, 8'hD8, 8'hAB, 8'hA1, 8'h83, 8'hD3
  };
  localparam logic [7:0] SysUuid [UuidLen] = '{
    8'h9A, 8'h04, 8'hF0, 8'h79, 8'h98, 8'h40, 8'h42, 8'h86,
    8'hAB, 8'h92, 8'hE6, 8'h5B, 8'hE0, 8'h88, 8'h5F, 8'h95
  };

  typedef enum logic [5:0] {
    PhHdr    = 6'b000001,
    PhTypeLo = 6'b000010,
    PhTypeHi = 6'b000100,
    PhLenLo  = 6'b001000,
    PhLenHi  = 6'b010000,
    PhSkip   = 6'b100000
  } prhf_phase_e;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] byte_value;
  } prhf_item_t;

  typedef struct packed {
    logic                 status;
    logic [OffsetW-1:0]   header_offset;
    logic [LengthW-1:0]   header_length;
  } prhf_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pssh_record_header_finder_core.sv
// Top level of the record header finder: input register, parser, result register.
//
//  channel  dir  tdata (low bit up)                          tlast
//  s_axis   in   byte_value[7:0]                             last_byte
//  m_axis   out  status, header_offset[31:0],                -
//                header_length[15:0], 7 zero bits
//
// One byte item is taken per cycle unless the input stalls; the parser step is
// combinational logic between the input register and the result register.
// The result register loads when the parser steps on the byte that causes it.
// rst_ni (async, active low) returns the parser to the start of a box.
// Input stalls only while a result waits in the result register and
// m_axis_tready is low.
`default_nettype none

module pssh_record_header_finder_core #(
  parameter int unsigned POSITION_BITS = prhf_pkg::PositionBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [prhf_pkg::InTdataW-1:0] s_axis_tdata,   // byte_value[7:0]
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [prhf_pkg::OutTdataW-1:0]     m_axis_tdata    // status, offset, length, pad
);

  prhf_pkg::prhf_item_t   in_item, st_item;
  prhf_pkg::prhf_result_t result;
  logic                   st_valid, space, step, emit;

  assign in_item = '{last_byte: s_axis_tlast, byte_value: s_axis_tdata};
  assign step    = st_valid && space;

  prhf_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .item_i    (in_item),
    .take_i    (step),
    .valid_o   (st_valid),
    .item_o    (st_item)
  );

  prhf_parser #(
    .PositionBits (POSITION_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (st_item),
    .emit_o   (emit),
    .result_o (result)
  );

  prhf_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step && emit),
    .result_i  (result),
    .space_o   (space),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/prhf_in_stage.sv
// Input register: holds one accepted byte item for the parser.
`default_nettype none

module prhf_in_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire prhf_pkg::prhf_item_t item_i,
  input  wire logic                take_i,
  output logic                     valid_o,
  output prhf_pkg::prhf_item_t     item_o
);

  logic                 valid_q;
  prhf_pkg::prhf_item_t item_q;

  assign s_ready_o = !valid_q || take_i;
  assign valid_o   = valid_q;
  assign item_o    = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_valid_i && s_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/prhf_parser.sv
// Parser state and the per-byte step logic.
`default_nettype none

module prhf_parser #(
  parameter int unsigned PositionBits = prhf_pkg::PositionBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire prhf_pkg::prhf_item_t item_i,
  output logic                      emit_o,
  output prhf_pkg::prhf_result_t    result_o
);

  localparam int unsigned FW = prhf_pkg::FieldW;
  localparam logic [PositionBits-1:0] PosMax     = '1;
  localparam logic [PositionBits-1:0] BoxLo      = PositionBits'(prhf_pkg::BoxUuidStart);
  localparam logic [PositionBits-1:0] BoxHi      =
    PositionBits'(prhf_pkg::BoxUuidStart + prhf_pkg::UuidLen);
  localparam logic [PositionBits-1:0] SysLo      = PositionBits'(prhf_pkg::SysUuidStart);
  localparam logic [PositionBits-1:0] SysHi      =
    PositionBits'(prhf_pkg::SysUuidStart + prhf_pkg::UuidLen);
  localparam logic [PositionBits-1:0] CntLoPos   = PositionBits'(prhf_pkg::CountLowPos);
  localparam logic [PositionBits-1:0] CntHiPos   = PositionBits'(prhf_pkg::RecordsStart - 1);
  localparam logic [3:0]              BoxIdxBase = 4'(prhf_pkg::BoxUuidStart);
  localparam logic [3:0]              SysIdxBase = 4'(prhf_pkg::SysUuidStart);

  logic [PositionBits-1:0] pos_q, pos_d;
  prhf_pkg::prhf_phase_e   phase_q, phase_d;
  logic [FW-1:0]           left_q, left_d;
  logic [FW-1:0]           asm_q, asm_d;
  logic [FW-1:0]           kind_q, kind_d;
  logic [FW-1:0]           skip_q, skip_d;
  logic                    given_q, given_d;

  logic [7:0]    b;
  logic [3:0]    box_idx, sys_idx;
  logic [FW-1:0] word, left_dec, skip_dec;

  assign b        = item_i.byte_value;
  assign box_idx  = pos_q[3:0] - BoxIdxBase;
  assign sys_idx  = pos_q[3:0] - SysIdxBase;
  assign word     = {b, asm_q[7:0]};
  assign left_dec = left_q - FW'(1);
  assign skip_dec = skip_q - FW'(1);

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    left_d   = left_q;
    asm_d    = asm_q;
    kind_d   = kind_q;
    skip_d   = skip_q;
    given_d  = given_q;
    emit_o   = 1'b0;
    result_o = '{status: 1'b1, header_offset: '0, header_length: '0};

    if (!given_q) begin
      unique case (phase_q)
        prhf_pkg::PhHdr: begin
          if (pos_q >= BoxLo && pos_q < BoxHi) begin
            if (b != prhf_pkg::BoxUuid[box_idx]) emit_o = 1'b1;
          end else if (pos_q >= SysLo && pos_q < SysHi) begin
            if (b != prhf_pkg::SysUuid[sys_idx]) emit_o = 1'b1;
          end else if (pos_q == CntLoPos) begin
            asm_d = {8'h00, b};
          end else if (pos_q == CntHiPos) begin
            left_d = word;
            if (word == '0) emit_o = 1'b1;
            else phase_d = prhf_pkg::PhTypeLo;
          end
        end
        prhf_pkg::PhTypeLo: begin
          asm_d   = {8'h00, b};
          phase_d = prhf_pkg::PhTypeHi;
        end
        prhf_pkg::PhTypeHi: begin
          kind_d  = word;
          phase_d = prhf_pkg::PhLenLo;
        end
        prhf_pkg::PhLenLo: begin
          asm_d   = {8'h00, b};
          phase_d = prhf_pkg::PhLenHi;
        end
        prhf_pkg::PhLenHi: begin
          if (kind_q == prhf_pkg::HeaderRecordType) begin
            emit_o                 = 1'b1;
            result_o.status        = 1'b0;
            result_o.header_offset = prhf_pkg::OffsetW'((pos_q == PosMax) ? PosMax
                                                                          : pos_q + 1'b1);
            result_o.header_length = word;
          end else begin
            left_d = left_dec;
            if (left_dec == '0) begin
              emit_o = 1'b1;
            end else if (word == '0) begin
              phase_d = prhf_pkg::PhTypeLo;
            end else begin
              skip_d  = word;
              phase_d = prhf_pkg::PhSkip;
            end
          end
        end
        prhf_pkg::PhSkip: begin
          skip_d = skip_dec;
          if (skip_dec == '0) phase_d = prhf_pkg::PhTypeLo;
        end
        default: begin
          emit_o = 1'b1;
        end
      endcase
      if (emit_o) given_d = 1'b1;
    end

    if (item_i.last_byte && !given_d) begin
      emit_o   = 1'b1;
      result_o = '{status: 1'b1, header_offset: '0, header_length: '0};
    end

    if (item_i.last_byte) begin
      pos_d   = '0;
      phase_d = prhf_pkg::PhHdr;
      left_d  = '0;
      asm_d   = '0;
      kind_d  = '0;
      skip_d  = '0;
      given_d = 1'b0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= prhf_pkg::PhHdr;
      left_q  <= '0;
      asm_q   <= '0;
      kind_q  <= '0;
      skip_q  <= '0;
      given_q <= 1'b0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      left_q  <= left_d;
      asm_q   <= asm_d;
      kind_q  <= kind_d;
      skip_q  <= skip_d;
      given_q <= given_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/prhf_out_stage.sv
// Result register: holds one result item until the sink takes it.
`default_nettype none

module prhf_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire prhf_pkg::prhf_result_t result_i,
  output logic                       space_o,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output logic [prhf_pkg::OutTdataW-1:0] m_data_o
);

  localparam int unsigned PadW =
    prhf_pkg::OutTdataW - 1 - prhf_pkg::OffsetW - prhf_pkg::LengthW;

  logic                   valid_q;
  prhf_pkg::prhf_result_t res_q;

  assign space_o   = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign m_data_o  = {{PadW{1'b0}}, res_q.header_length, res_q.header_offset, res_q.status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/prhf_checker.sv
// Port-level checker for the record header finder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module prhf_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [prhf_pkg::OutTdataW-1:0] m_axis_tdata
);

  // stalled result holds
  `PRHF_ASSERT_IMPL(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    ##1 (m_axis_tvalid && $stable(m_axis_tdata)))
  // input backpressure only comes from a stalled result
  `PRHF_ASSERT_IMPL(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // failure carries zero offset and length
  `PRHF_ASSERT_IMPL(a_fail_zero, m_axis_tvalid && m_axis_tdata[0],
                    m_axis_tdata[48:1] == 48'd0)
  // success cannot point before the first record's data
  `PRHF_ASSERT_IMPL(a_ok_offset, m_axis_tvalid && !m_axis_tdata[0],
                    m_axis_tdata[32:1] >= 32'd58)

endmodule

bind pssh_record_header_finder_core prhf_checker u_prhf_checker (.*);

`default_nettype wire
